// ===== rtl/bilinear_row_sampler_defines.svh =====
// Assertion macros for the row sampler checker.
`ifndef BILINEAR_ROW_SAMPLER_DEFINES_SVH
`define BILINEAR_ROW_SAMPLER_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define BRS_ASSERT_IMPL(label, clk, rstn, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
        else $error("bilinear_row_sampler check failed");
// Implication whose consequent is checked in the cycle after the antecedent.
`define BRS_ASSERT_NEXT(label, clk, rstn, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
        else $error("bilinear_row_sampler check failed");
`endif

// ===== rtl/brs_pkg.sv =====
package brs_pkg;
    localparam int StoreBytesDefault   = 65536;
    localparam int FractionBitsDefault = 16;

    typedef enum logic [1:0] {
        MODE_WRITE = 2'd0,
        MODE_START = 2'd1,
        MODE_NEXT  = 2'd2,
        MODE_NONE  = 2'd3
    } mode_t;

    localparam logic [2:0] REG_WIDTH  = 3'd0;
    localparam logic [2:0] REG_HEIGHT = 3'd1;
    localparam logic [2:0] REG_STRIDE = 3'd2;
    localparam logic [2:0] REG_BPP    = 3'd3;
    localparam logic [2:0] REG_STEPX  = 3'd4;
    localparam logic [2:0] REG_STEPY  = 3'd5;

    // sample command from front to back: clamped point split into cell and fraction
    typedef struct packed {
        logic [12:0] x0;
        logic [12:0] y0;
        logic        xi;
        logic        yi;
        logic [15:0] fx;
        logic [15:0] fy;
    } cmd_t;
endpackage

// ===== rtl/brs_front.sv =====
module brs_front #(
    parameter int FRACTION_BITS = brs_pkg::FractionBitsDefault
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         in_mode,
    input  logic [31:0]        in_x,
    input  logic [31:0]        in_y,
    input  logic [12:0]        image_width,
    input  logic [12:0]        image_height,
    input  logic [31:0]        step_x,
    input  logic [31:0]        step_y,
    output logic               q_valid,
    input  logic               q_ready,
    output brs_pkg::cmd_t      q_cmd
);
    logic [31:0] cur_x_reg, cur_y_reg;
    logic [31:0] px, py;
    logic [1:0]  cnt_reg;
    brs_pkg::cmd_t buf_reg [2];
    logic        wr_reg, rd_reg;
    logic        sample;
    brs_pkg::cmd_t cmd;

    function automatic logic [31:0] clampc(input logic [31:0] v, input logic [12:0] sz);
        logic [44:0] hi;
        hi = 45'(sz == 13'd0 ? 13'd0 : sz - 13'd1) << FRACTION_BITS;
        if (v[31]) return 32'd0;
        if (45'(v) > hi) return hi[31:0];
        return v;
    endfunction

    assign sample = in_valid && in_ready &&
        (in_mode == brs_pkg::MODE_START || in_mode == brs_pkg::MODE_NEXT);
    assign in_ready = cnt_reg != 2'd2;
    assign px = in_mode == brs_pkg::MODE_START ? in_x : cur_x_reg;
    assign py = in_mode == brs_pkg::MODE_START ? in_y : cur_y_reg;

    always_comb begin
        logic [31:0] cx, cy;
        cx = clampc(px, image_width);
        cy = clampc(py, image_height);
        cmd.x0 = 13'(cx >> FRACTION_BITS);
        cmd.y0 = 13'(cy >> FRACTION_BITS);
        cmd.fx = 16'(cx[FRACTION_BITS-1:0]);
        cmd.fy = 16'(cy[FRACTION_BITS-1:0]);
        cmd.xi = cx[FRACTION_BITS-1:0] != '0;
        cmd.yi = cy[FRACTION_BITS-1:0] != '0;
    end

    assign q_valid = cnt_reg != 2'd0;
    assign q_cmd = buf_reg[rd_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_x_reg <= '0;
            cur_y_reg <= '0;
            cnt_reg   <= '0;
            wr_reg    <= 1'b0;
            rd_reg    <= 1'b0;
        end else begin
            if (sample) begin
                cur_x_reg <= px + step_x;
                cur_y_reg <= py + step_y;
                buf_reg[wr_reg] <= cmd;
                wr_reg <= ~wr_reg;
            end
            if (q_valid && q_ready) rd_reg <= ~rd_reg;
            cnt_reg <= cnt_reg + 2'(sample) - 2'(q_valid && q_ready);
        end
    end
endmodule

// ===== rtl/brs_back.sv =====
module brs_back #(
    parameter int STORE_BYTES   = brs_pkg::StoreBytesDefault,
    parameter int FRACTION_BITS = brs_pkg::FractionBitsDefault,
    localparam int AW = $clog2(STORE_BYTES)
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          wr_en,
    input  logic [15:0]   wr_addr,
    input  logic [7:0]    wr_data,
    input  logic          q_valid,
    output logic          q_ready,
    input  brs_pkg::cmd_t q_cmd,
    input  logic [14:0]   row_stride,
    input  logic [2:0]    bytes_per_pixel,
    output logic          fetch_idle,
    output logic          m_valid,
    input  logic          m_ready,
    output logic [31:0]   m_data
);
    localparam logic [16:0] One = 17'(1) << FRACTION_BITS;
    logic [7:0]  mem [STORE_BYTES];
    logic [7:0]  rd_data_reg;
    logic        busy_reg;
    brs_pkg::cmd_t c_reg;
    logic [3:0]  step_reg;    // bits 3:2 channel, 1:0 neighbor
    logic        rd_pend_reg;
    logic [1:0]  pend_n_reg;
    logic [1:0]  pend_b_reg;
    logic        pend_last_reg;
    logic [33:0] wprod_reg;
    logic [41:0] acc_reg;
    logic [7:0]  res_reg [4];
    logic [31:0] rd_addr;
    logic [16:0] wa, wb;
    logic [31:0] full_addr;

    always_comb begin
        logic [12:0] xs, ys;
        xs = step_reg[0] ? c_reg.x0 + 13'(c_reg.xi) : c_reg.x0;
        ys = step_reg[1] ? c_reg.y0 + 13'(c_reg.yi) : c_reg.y0;
        full_addr = 32'(ys) * 32'(row_stride) + 32'(bytes_per_pixel) * 32'(xs)
                  + 32'(step_reg[3:2]);
        rd_addr = full_addr;
        wa = step_reg[0] ? 17'(c_reg.fx) : One - 17'(c_reg.fx);
        wb = step_reg[1] ? 17'(c_reg.fy) : One - 17'(c_reg.fy);
    end

    // take a new sample only once the last result has left and no fetch is in flight
    assign q_ready = !busy_reg && !m_valid && !rd_pend_reg;
    assign fetch_idle = !busy_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) mem[AW'(wr_addr)] <= wr_data;
        rd_data_reg <= mem[rd_addr[AW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            m_valid     <= 1'b0;
            rd_pend_reg <= 1'b0;
            step_reg    <= '0;
        end else begin
            if (m_valid && m_ready) m_valid <= 1'b0;
            if (q_valid && q_ready) begin
                c_reg    <= q_cmd;
                busy_reg <= 1'b1;
                step_reg <= '0;
                acc_reg  <= '0;
            end
            rd_pend_reg <= busy_reg && !rd_pend_reg;
            if (busy_reg && !rd_pend_reg) begin
                // issue fetch; weight product registered alongside
                wprod_reg     <= 34'(wa) * 34'(wb);
                pend_n_reg    <= step_reg[1:0];
                pend_b_reg    <= step_reg[3:2];
                pend_last_reg <= step_reg == 4'hF;
                step_reg      <= step_reg + 4'd1;
                if (step_reg == 4'hF) busy_reg <= 1'b0;
            end
            if (rd_pend_reg) begin
                logic [41:0] s;
                s = acc_reg + 42'(wprod_reg) * 42'(rd_data_reg);
                if (pend_n_reg == 2'd3) begin
                    logic [41:0] v;
                    v = s >> (2 * FRACTION_BITS);
                    res_reg[pend_b_reg] <= (3'(pend_b_reg) >= bytes_per_pixel) ? 8'd0
                                         : (v > 42'd255 ? 8'd255 : v[7:0]);
                    acc_reg <= '0;
                end else begin
                    acc_reg <= s;
                end
                if (pend_last_reg) m_valid <= 1'b1;
            end
        end
    end

    assign m_data = {res_reg[3], res_reg[2], res_reg[1], res_reg[0]};
endmodule

// ===== rtl/bilinear_row_sampler.sv =====
// Bilinear row sampler. Mode-0 words write one byte into the on-chip image store;
// mode-1 words start a run at (start_x, start_y) and mode-2 words sample the next
// point of the run, each giving one word of four 8-bit channels on m_. The front
// clamps and splits the point and advances it by (step_x, step_y); a two-entry
// queue feeds the back, which reads the store sixteen times per sample (four
// neighbors for each of four channels), each read issued and then accumulated
// before the next is issued. The back takes a new sample only once the last
// result has left; a stalled result holds the back, and the input stalls once
// two samples wait in the queue. A byte write is held while any accepted sample
// has store reads left. Configure only while idle.
module bilinear_row_sampler #(
    parameter int STORE_BYTES   = brs_pkg::StoreBytesDefault,
    parameter int FRACTION_BITS = brs_pkg::FractionBitsDefault
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // s_tuser: mode[1:0]
    input  logic [1:0]   s_tuser,
    // s_tdata: byte_address[15:0], byte_value[23:16], start_x[55:24], start_y[87:56]
    input  logic [87:0]  s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // m_tdata: channel_0[7:0], channel_1[15:8], channel_2[23:16], channel_3[31:24]
    output logic [31:0]  m_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data
);
    logic [12:0] width_reg, height_reg;
    logic [14:0] stride_reg;
    logic [2:0]  bpp_reg;
    logic [31:0] stepx_reg, stepy_reg;
    logic        fr_ready, q_valid, q_ready, wr_en, back_idle;
    brs_pkg::cmd_t q_cmd;

    assign cfg_ready = 1'b1;
    // hold a byte write until every queued sample has finished its store reads
    assign s_tready = fr_ready &&
        (s_tuser != brs_pkg::MODE_WRITE || (!q_valid && back_idle));
    assign wr_en = s_tvalid && s_tready && s_tuser == brs_pkg::MODE_WRITE;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= 13'd1;
            height_reg <= 13'd1;
            stride_reg <= 15'd1;
            bpp_reg    <= 3'd1;
            stepx_reg  <= 32'd65536;
            stepy_reg  <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                brs_pkg::REG_WIDTH:  width_reg  <= cfg_data[12:0];
                brs_pkg::REG_HEIGHT: height_reg <= cfg_data[12:0];
                brs_pkg::REG_STRIDE: stride_reg <= cfg_data[14:0];
                brs_pkg::REG_BPP:    bpp_reg    <= cfg_data[2:0];
                brs_pkg::REG_STEPX:  stepx_reg  <= cfg_data;
                brs_pkg::REG_STEPY:  stepy_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    brs_front #(.FRACTION_BITS(FRACTION_BITS)) u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_ready(fr_ready), .in_mode(s_tuser),
        .in_x(s_tdata[55:24]), .in_y(s_tdata[87:56]),
        .image_width(width_reg), .image_height(height_reg),
        .step_x(stepx_reg), .step_y(stepy_reg),
        .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd)
    );

    brs_back #(.STORE_BYTES(STORE_BYTES), .FRACTION_BITS(FRACTION_BITS)) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .wr_en(wr_en), .wr_addr(s_tdata[15:0]), .wr_data(s_tdata[23:16]),
        .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd),
        .row_stride(stride_reg), .bytes_per_pixel(bpp_reg),
        .fetch_idle(back_idle),
        .m_valid(m_tvalid), .m_ready(m_tready), .m_data(m_tdata)
    );
endmodule

// ===== rtl/brs_checker.sv =====
`include "bilinear_row_sampler_defines.svh"
module brs_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);
    `BRS_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `BRS_ASSERT_IMPL(a_out_known, aclk, aresetn, m_tvalid, !$isunknown(m_tdata))
    `BRS_ASSERT_NEXT(a_out_gap, aclk, aresetn, m_tvalid && m_tready, !m_tvalid)
endmodule

bind bilinear_row_sampler brs_checker u_brs_checker (
    .aclk(aclk), .aresetn(aresetn),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
